>>> rtl/chacha20_block_keystream_core_assert.svh
// Assertion shorthands for the top-level core, the one file that includes them.
`ifndef CHACHA20_BLOCK_KEYSTREAM_CORE_ASSERT_SVH
`define CHACHA20_BLOCK_KEYSTREAM_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define CHBK_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define CHBK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/chbk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chbk_pkg;

  localparam int unsigned WordW          = 32;
  localparam int unsigned BlockWords     = 16;
  localparam int unsigned WordIdxW       = $clog2(BlockWords);
  localparam int unsigned DefDoubleRounds = 10;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned QueuePtrW      = $clog2(QueueDepth);
  localparam int unsigned QueueCntW      = $clog2(QueueDepth + 1);

  typedef logic [WordW-1:0] word_t;
  typedef logic [BlockWords-1:0][WordW-1:0] block_t;

  // One request as it travels from the front end to the round engine.
  typedef struct packed {
    word_t word;
    logic  last;
  } entry_t;

  // Status the round engine reports to the top level.
  typedef struct packed {
    logic loading;
    logic in_rounds;
    logic emitting;
  } back_status_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (WordW - n));
  endfunction

  // One quarter round on words a, b, c, d of the block.
  function automatic block_t quarter(input block_t s, input int unsigned a,
                                     input int unsigned b, input int unsigned c,
                                     input int unsigned d);
    block_t t;
    t = s;
    t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 16);
    t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 12);
    t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 8);
    t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 7);
    quarter = t;
  endfunction

  // The four quarter rounds of one half round touch disjoint words.
  function automatic block_t half_round(input block_t s, input logic diag);
    block_t t;
    t = s;
    if (!diag) begin
      t = quarter(t, 0, 4, 8, 12);
      t = quarter(t, 1, 5, 9, 13);
      t = quarter(t, 2, 6, 10, 14);
      t = quarter(t, 3, 7, 11, 15);
    end else begin
      t = quarter(t, 0, 5, 10, 15);
      t = quarter(t, 1, 6, 11, 12);
      t = quarter(t, 2, 7, 8, 13);
      t = quarter(t, 3, 4, 9, 14);
    end
    half_round = t;
  endfunction

endpackage

`default_nettype wire

>>> rtl/chbk_front.sv
`timescale 1ns / 1ps
`default_nettype none

module chbk_front
  import chbk_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  input  wire word_t  state_word_i,
  output logic        in_ready_o,
  input  wire logic   q_full_i,
  output logic        q_push_o,
  output entry_t      q_entry_o
);

  logic [WordIdxW-1:0] idx_q, idx_d;

  assign in_ready_o     = !q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i;
  assign q_entry_o.word = state_word_i;
  assign q_entry_o.last = (idx_q == WordIdxW'(BlockWords - 1));

  // The index wraps by itself after the sixteenth word.
  assign idx_d = q_push_o ? idx_q + WordIdxW'(1) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/chbk_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module chbk_queue
  import chbk_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output entry_t      pop_entry_o
);

  entry_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o      = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o     = (cnt_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign pop_entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/chbk_back.sv
`timescale 1ns / 1ps
`default_nettype none

module chbk_back
  import chbk_pkg::*;
#(
  parameter int unsigned DoubleRounds = DefDoubleRounds
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_empty_i,
  input  wire entry_t q_entry_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output word_t       keystream_word_o,
  output logic        last_word_o,
  output back_status_t status_o
);

  localparam int unsigned HalfRounds = 2 * DoubleRounds;
  localparam int unsigned HalfW      = (HalfRounds > 1) ? $clog2(HalfRounds) : 1;

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  logic [1:0]          state_q;
  logic [WordIdxW-1:0] idx_q;
  logic [HalfW-1:0]    half_q;
  block_t              orig_q, work_q;
  logic                out_valid_q, out_last_q;
  word_t               out_word_q;
  logic                out_free;
  word_t               sum;

  assign q_pop_o  = (state_q == StLoad) && !q_empty_i;
  assign out_free = !out_valid_q || out_ready_i;
  assign sum      = work_q[idx_q] + orig_q[idx_q];

  assign out_valid_o      = out_valid_q;
  assign keystream_word_o = out_word_q;
  assign last_word_o      = out_last_q;

  assign status_o.loading   = (state_q == StLoad);
  assign status_o.in_rounds = (state_q == StRound);
  assign status_o.emitting  = (state_q == StEmit);

  // Block data: no reset, every word is loaded before it is read.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      orig_q[idx_q] <= q_entry_i.word;
      work_q[idx_q] <= q_entry_i.word;
    end else if (state_q == StRound) begin
      work_q <= half_round(work_q, half_q[0]);
    end
    if ((state_q == StEmit) && out_free) begin
      out_word_q <= sum;
      out_last_q <= (idx_q == WordIdxW'(BlockWords - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      idx_q       <= '0;
      half_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == StEmit) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StLoad: begin
          if (q_pop_o) begin
            if (q_entry_i.last) begin
              idx_q   <= '0;
              half_q  <= '0;
              state_q <= StRound;
            end else begin
              idx_q <= idx_q + WordIdxW'(1);
            end
          end
        end
        StRound: begin
          if (half_q == HalfW'(HalfRounds - 1)) begin
            state_q <= StEmit;
          end else begin
            half_q <= half_q + HalfW'(1);
          end
        end
        StEmit: begin
          if (out_free) begin
            idx_q <= idx_q + WordIdxW'(1);
            if (idx_q == WordIdxW'(BlockWords - 1)) begin
              state_q <= StLoad;
            end
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/chacha20_block_keystream_core.sv
// The sixteenth state word passes the queue to the round engine; after the half rounds it
// registers the first keystream word, and the other fifteen follow one per cycle unstalled.
// Throughput is set by the round engine, which loads sixteen words, runs one half round per
// cycle and emits sixteen words in turn; it loads the next block after the last word is out.
// Reset: rst_ni is asynchronous and active low; it empties the queue, clears the word index
// and the output valid, and returns the round engine to loading.
`timescale 1ns / 1ps
`default_nettype none
`include "chacha20_block_keystream_core_assert.svh"

module chacha20_block_keystream_core
  import chbk_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUND_COUNT = DefDoubleRounds
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] state_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      keystream_word_o,
  output logic             last_word_o
);

  logic         q_full, q_push, q_pop, q_empty;
  entry_t       push_entry, pop_entry;
  back_status_t back_status;
  logic         out_stall;
  logic [32:0]  out_bus;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_bus   = {last_word_o, keystream_word_o};

  chbk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .state_word_i (state_word_i),
    .in_ready_o   (in_ready_o),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (push_entry)
  );

  chbk_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .pop_entry_o  (pop_entry)
  );

  chbk_back #(
    .DoubleRounds (DOUBLE_ROUND_COUNT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_entry_i        (pop_entry),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .keystream_word_o (keystream_word_o),
    .last_word_o      (last_word_o),
    .status_o         (back_status)
  );

  // The engine must never pull a request it cannot see, nor pull outside its loading phase.
  `CHBK_ASSERT_SAME(a_pop_not_empty, q_pop, !q_empty && back_status.loading, "bad pop")
  // A full queue must stall the input side.
  `CHBK_ASSERT_SAME(a_full_stalls, q_full, !in_ready_o && !q_push, "input taken when full")
  // A stalled keystream word stays valid and unchanged.
  `CHBK_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_bus), "output changed")
  // The round engine is always in exactly one phase.
  `CHBK_ASSERT_SAME(a_one_phase, 1'b1, $onehot(back_status), "engine phase not one-hot")

endmodule

`default_nettype wire

>>> dv/chbk_keystream_checker.sv
`timescale 1ns / 1ps

module chbk_keystream_checker
  import chbk_pkg::*;
#(
  parameter int unsigned RoundPairs = DefDoubleRounds
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [31:0] state_word_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] keystream_word_i,
  input  wire logic        last_word_i,
  output int               mismatches_o,
  output int               pending_o,
  output int               blocks_o,
  output int               results_o
);

  typedef struct {
    word_t word;
    logic  last;
  } keystream_exp_t;

  word_t               block_words [BlockWords];
  word_t               mix_words [BlockWords];
  logic [WordIdxW-1:0] word_idx;
  keystream_exp_t      keystream_q [$];
  int                  err_count = 0;
  int                  block_count = 0;
  int                  result_count = 0;

  assign mismatches_o = err_count;
  assign blocks_o     = block_count;
  assign results_o    = result_count;

  function automatic word_t rot_left(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  function automatic void quarter_mix(input int unsigned a, input int unsigned b,
                                      input int unsigned c, input int unsigned d);
    mix_words[a] += mix_words[b];
    mix_words[d] = rot_left(mix_words[d] ^ mix_words[a], 16);
    mix_words[c] += mix_words[d];
    mix_words[b] = rot_left(mix_words[b] ^ mix_words[c], 12);
    mix_words[a] += mix_words[b];
    mix_words[d] = rot_left(mix_words[d] ^ mix_words[a], 8);
    mix_words[c] += mix_words[d];
    mix_words[b] = rot_left(mix_words[b] ^ mix_words[c], 7);
  endfunction

  // Runs the rounds on a copy of the stored request words and queues the sixteen
  // keystream words that the block owes for it.
  function automatic void predict_block();
    mix_words = block_words;
    for (int r = 0; r < RoundPairs; r++) begin
      for (int i = 0; i < 4; i++) quarter_mix(i, i + 4, i + 8, i + 12);
      // Diagonals: row j of the quarter round is shifted left by j columns.
      for (int i = 0; i < 4; i++) begin
        quarter_mix(i, (i + 1) % 4 + 4, (i + 2) % 4 + 8, (i + 3) % 4 + 12);
      end
    end
    for (int k = 0; k < BlockWords; k++) begin
      keystream_q.push_back('{word: mix_words[k] + block_words[k],
                              last: (k == BlockWords - 1)});
    end
  endfunction

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    keystream_exp_t want;
    logic           bad;
    if (!rst_ni) begin
      word_idx <= '0;
      keystream_q.delete();
      pending_o <= 0;
    end else begin
      // Results are checked before a new request can add to the queue.
      if (out_valid_i && out_ready_i) begin
        result_count++;
        if (keystream_q.size() == 0) begin
          flag_error($sformatf("Unexpected keystream word %08h last %0b at %0t.",
                               keystream_word_i, last_word_i, $realtime));
        end else begin
          want = keystream_q.pop_front();
          bad  = 1'b0;
          if (keystream_word_i !== want.word) bad = 1'b1;
          if (last_word_i !== want.last) bad = 1'b1;
          if (bad) begin
            flag_error($sformatf(
              "Keystream mismatch at %0t: expected %08h last %0b, got %08h last %0b.",
              $realtime, want.word, want.last, keystream_word_i, last_word_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        block_words[word_idx] = state_word_i;
        if (word_idx == WordIdxW'(BlockWords - 1)) begin
          predict_block();
          block_count++;
        end
        word_idx <= word_idx + WordIdxW'(1);
      end
      pending_o <= keystream_q.size();
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import chbk_pkg::*;

  localparam int unsigned DoubleRounds = DefDoubleRounds;
  localparam int RandomBlocks = 22;
  localparam int DrainCycles  = 2 * DoubleRounds + 40;
  localparam int DrainLimit   = 20000;
  localparam logic [3:0][31:0] Sigma = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  typedef enum int {
    FillRandom,
    FillSigmaKey,
    FillZero,
    FillOnes
  } block_fill_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] state_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] keystream_word_o;
  logic        last_word_o;

  int mismatches;
  int pending;
  int blocks;
  int results;
  int words_sent;
  bit calm;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  chacha20_block_keystream_core #(
    .DOUBLE_ROUND_COUNT(DoubleRounds)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .state_word_i    (state_word_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .keystream_word_o(keystream_word_o),
    .last_word_o     (last_word_o)
  );

  chbk_keystream_checker #(
    .RoundPairs(DoubleRounds)
  ) keystream_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .state_word_i    (state_word_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .keystream_word_i(keystream_word_o),
    .last_word_i     (last_word_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .blocks_o        (blocks),
    .results_o       (results)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(31);
      3:       return ~(word_t'(1) << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  // Holds the request until it is taken, then maybe idles the sender for a while.
  task automatic send_word(input word_t w);
    int gap;
    in_valid_i   <= 1'b1;
    state_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_block(input block_fill_e fill);
    word_t w;
    for (int k = 0; k < BlockWords; k++) begin
      case (fill)
        FillSigmaKey: w = (k < 4) ? Sigma[k] : pick_word();
        FillZero:     w = '0;
        FillOnes:     w = '1;
        default:      w = pick_word();
      endcase
      send_word(w);
    end
  endtask

  task automatic wait_drained();
    int k;
    k = 0;
    @(posedge clk_i);
    while (pending != 0 && k < DrainLimit) begin
      @(posedge clk_i);
      k++;
    end
  endtask

  initial begin
    int          hold;
    logic        rdy;
    out_ready_i = 1'b0;
    hold = 0;
    rdy  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm) begin
        rdy  = 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        rdy  = !rdy;
        if (rdy) hold = $urandom_range(12, 0);
        else hold = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(2, 0);
      end
      out_ready_i <= rdy;
    end
  end

  initial begin
    block_fill_e fill;
    word_t       w;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    state_word_i = '0;
    calm         = 1'b0;
    words_sent   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A sigma header, alternating all-zero and all-one key words, a saturated
    // counter and a zero nonce.
    for (int k = 0; k < BlockWords; k++) begin
      if (k < 4) w = Sigma[k];
      else if (k < 12) w = (k % 2 != 0) ? '1 : '0;
      else if (k == 12) w = '1;
      else w = '0;
      send_word(w);
    end

    for (int b = 0; b < RandomBlocks; b++) begin
      calm = (b >= 6 && b < 9);
      if (b == 4 || b == 15) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      case ($urandom_range(9))
        0:       fill = FillZero;
        1:       fill = FillOnes;
        2, 3, 4: fill = FillSigmaKey;
        default: fill = FillRandom;
      endcase
      send_block(fill);
    end
    calm = 1'b0;

    // A partial block at the end must not produce any keystream.
    repeat (3) send_word(pick_word());
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d keystream blocks from %0d state words, %0d keystream words seen.",
             blocks, words_sent, results);
    $display("Fills: extremes, sigma headers with random keys, random words; stalls both sides.");
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
